[design/pev_pkg.sv]
// shared types and constants for the polynomial evaluator
// request and response of the multi-cycle multiply unit, saturation limits
package pev_pkg;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q32_ONE = 64'sh0000_0001_0000_0000;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [31:0] b;
        logic               shift16;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
        logic               ovf;
    } mul_rsp_t;

endpackage

[design/pev_ram.sv]
// generic single-port synchronous ram with registered read
// no dependencies
module pev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[design/pev_mul.sv]
// saturating fixed-point multiply (a * b) >> s, s is 0 or 16, magnitude truncation
// one 32x32 multiplier used twice; uses pev_pkg
module pev_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  pev_pkg::mul_req_t req,
    output pev_pkg::mul_rsp_t rsp
);

    import pev_pkg::*;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_LO   = 3'd1;
    localparam logic [2:0] M_HI   = 3'd2;
    localparam logic [2:0] M_SUM  = 3'd3;
    localparam logic [2:0] M_FIN  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               done_reg, done_next;
    logic               neg_reg;
    logic               sh_reg;
    logic [63:0]        ma_reg;
    logic [31:0]        mb_reg;
    logic [63:0]        lo_reg;
    logic [63:0]        hi_reg;
    logic [63:0]        m_reg;
    logic               ovf_reg;
    logic signed [63:0] res_reg;
    logic               res_ovf_reg;

    logic [31:0] mult_sel;
    logic [63:0] prod;
    logic        ovf_hi;
    logic [63:0] hs;
    logic [63:0] lsh;
    logic [64:0] sum;
    logic        ovf_all;

    assign mult_sel = (state_reg == M_LO) ? ma_reg[31:0] : ma_reg[63:32];
    assign prod     = 64'(mult_sel) * 64'(mb_reg);

    always_comb
    begin
        ovf_hi = sh_reg ? (hi_reg[63:48] != 16'd0) : (hi_reg[63:32] != 32'd0);
        hs     = sh_reg ? {hi_reg[47:0], 16'd0} : {hi_reg[31:0], 32'd0};
        lsh    = sh_reg ? {16'd0, lo_reg[63:16]} : lo_reg;
        sum    = {1'b0, hs} + {1'b0, lsh};
        ovf_all = ovf_reg | (neg_reg ? (m_reg > 64'h8000_0000_0000_0000) : m_reg[63]);
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    state_next = M_LO;
                end
            end
            M_LO:  state_next = M_HI;
            M_HI:  state_next = M_SUM;
            M_SUM: state_next = M_FIN;
            M_FIN:
            begin
                state_next = M_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    neg_reg <= req.a[63] ^ req.b[31];
                    sh_reg  <= req.shift16;
                    ma_reg  <= req.a[63] ? (~req.a + 64'd1) : req.a;
                    mb_reg  <= req.b[31] ? (~req.b + 32'd1) : req.b;
                end
            end
            M_LO:  lo_reg <= prod;
            M_HI:  hi_reg <= prod;
            M_SUM:
            begin
                m_reg   <= sum[63:0];
                ovf_reg <= ovf_hi | sum[64];
            end
            M_FIN:
            begin
                res_ovf_reg <= ovf_all;
                if (ovf_all)
                begin
                    res_reg <= neg_reg ? SAT_MIN : SAT_MAX;
                end
                else
                begin
                    res_reg <= neg_reg ? signed'(~m_reg + 64'd1) : signed'(m_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
    assign rsp.ovf   = res_ovf_reg;

endmodule

[design/polynomial_eval_with_derivatives.sv]
// polynomial evaluator with first and second derivative, coefficients in one ram
// each active step is one pass of the shared multiply unit, up to six steps per coefficient
// one transaction at a time; the result register frees the input side while a result waits
// reset clears control state and the degree register; the coefficient ram is not cleared
// uses pev_pkg, pev_ram, pev_mul
module polynomial_eval_with_derivatives #(
    parameter int MAX_DEGREE = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         degree,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [7:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] x_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] poly_value,
    output logic signed [63:0] first_deriv,
    output logic signed [63:0] second_deriv,
    output logic               saturated
);

    import pev_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int KW    = $clog2(DEPTH);
    localparam int KKW   = 2 * KW;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [2:0] STEP_POW = 3'd0;
    localparam logic [2:0] STEP_V   = 3'd1;
    localparam logic [2:0] STEP_P1  = 3'd2;
    localparam logic [2:0] STEP_P1K = 3'd3;
    localparam logic [2:0] STEP_P2  = 3'd4;
    localparam logic [2:0] STEP_P2K = 3'd5;

    function automatic logic [64:0] add_sat(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic [63:0] s;
        logic        ovf;
        s   = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (ovf)
        begin
            return {1'b1, a[63] ? SAT_MIN : SAT_MAX};
        end
        return {1'b0, s};
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [KW-1:0]      n_reg, n_next;
    logic [KKW-1:0]     kk_reg, kk_next;
    logic [7:0]         deg_reg, deg_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [63:0] pk_reg, pk_next;
    logic signed [63:0] pk1_reg, pk1_next;
    logic signed [63:0] pk2_reg, pk2_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] v_reg, v_next;
    logic signed [63:0] vp_reg, vp_next;
    logic signed [63:0] vpp_reg, vpp_next;
    logic               sat_reg, sat_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [63:0] poly_reg, first_reg, second_reg;
    logic               sat_out_reg;

    logic               in_accept;
    logic               out_load;
    logic               step_on;
    logic               last_step;
    logic [31:0]        idx_full;
    logic [31:0]        deg_full;
    logic [31:0]        n_full;
    logic               ram_we;
    logic [KW-1:0]      ram_addr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] coef;
    logic [64:0]        acc;
    mul_req_t           mreq;
    mul_rsp_t           mrsp;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign idx_full = 32'(coef_index);
    assign deg_full = 32'(deg_reg);
    assign n_full   = (deg_full > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : deg_full;

    assign ram_we   = in_accept && (op == OP_LOAD) && (idx_full <= 32'(MAX_DEGREE));
    assign ram_addr = (state_reg == S_IDLE) ? idx_full[KW-1:0] : k_reg;
    assign coef     = signed'(ram_rdata);

    pev_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (coef_value),
        .rdata (ram_rdata)
    );

    pev_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    always_comb
    begin
        case (step_reg)
            STEP_POW:           step_on = (k_reg != '0);
            STEP_V:             step_on = 1'b1;
            STEP_P1, STEP_P1K:  step_on = (k_reg != '0);
            STEP_P2, STEP_P2K:  step_on = (k_reg > KW'(1));
            default:            step_on = 1'b0;
        endcase
        last_step = (step_reg == STEP_P2K);
    end

    always_comb
    begin
        mreq.start   = (state_reg == S_ISSUE) && step_on;
        mreq.shift16 = !(step_reg inside {STEP_P1K, STEP_P2K});
        case (step_reg)
            STEP_POW:
            begin
                mreq.a = pk_reg;
                mreq.b = x_reg;
            end
            STEP_V:
            begin
                mreq.a = pk_reg;
                mreq.b = coef;
            end
            STEP_P1:
            begin
                mreq.a = pk1_reg;
                mreq.b = coef;
            end
            STEP_P1K:
            begin
                mreq.a = t_reg;
                mreq.b = signed'(32'(k_reg));
            end
            STEP_P2:
            begin
                mreq.a = pk2_reg;
                mreq.b = coef;
            end
            STEP_P2K:
            begin
                mreq.a = t_reg;
                mreq.b = signed'(32'(kk_reg));
            end
            default:
            begin
                mreq.a = pk_reg;
                mreq.b = coef;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        kk_next    = kk_reg;
        deg_next   = deg_reg;
        x_next     = x_reg;
        pk_next    = pk_reg;
        pk1_next   = pk1_reg;
        pk2_next   = pk2_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        vp_next    = vp_reg;
        vpp_next   = vpp_reg;
        sat_next   = sat_reg;
        out_load   = 1'b0;
        acc        = '0;

        if (cfg_valid && cfg_ready)
        begin
            deg_next = degree;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (op == OP_EVAL))
                begin
                    state_next = S_FETCH;
                    step_next  = STEP_POW;
                    k_next     = '0;
                    kk_next    = '0;
                    n_next     = n_full[KW-1:0];
                    x_next     = x_value;
                    pk_next    = Q32_ONE;
                    pk1_next   = '0;
                    pk2_next   = '0;
                    v_next     = '0;
                    vp_next    = '0;
                    vpp_next   = '0;
                    sat_next   = 1'b0;
                end
            end
            S_FETCH:
            begin
                state_next = S_ISSUE;
            end
            S_ISSUE, S_WAIT:
            begin
                if ((state_reg == S_ISSUE) && step_on)
                begin
                    state_next = S_WAIT;
                end
                else if ((state_reg == S_ISSUE) || mrsp.done)
                begin
                    if (state_reg == S_WAIT)
                    begin
                        sat_next = sat_reg | mrsp.ovf;
                        case (step_reg)
                            STEP_POW:
                            begin
                                pk2_next = pk1_reg;
                                pk1_next = pk_reg;
                                pk_next  = mrsp.value;
                            end
                            STEP_V:
                            begin
                                acc      = add_sat(v_reg, mrsp.value);
                                v_next   = acc[63:0];
                                sat_next = sat_reg | mrsp.ovf | acc[64];
                            end
                            STEP_P1K:
                            begin
                                acc      = add_sat(vp_reg, mrsp.value);
                                vp_next  = acc[63:0];
                                sat_next = sat_reg | mrsp.ovf | acc[64];
                            end
                            STEP_P2K:
                            begin
                                acc      = add_sat(vpp_reg, mrsp.value);
                                vpp_next = acc[63:0];
                                sat_next = sat_reg | mrsp.ovf | acc[64];
                            end
                            default:
                            begin
                                t_next = mrsp.value;
                            end
                        endcase
                    end
                    if (!last_step)
                    begin
                        step_next  = step_reg + 3'd1;
                        state_next = S_ISSUE;
                    end
                    else if (k_reg == n_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        step_next  = STEP_POW;
                        k_next     = k_reg + KW'(1);
                        kk_next    = kk_reg + KKW'({k_reg, 1'b0});
                        state_next = S_FETCH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_POW;
            k_reg         <= '0;
            n_reg         <= '0;
            kk_reg        <= '0;
            deg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            kk_reg        <= kk_next;
            deg_reg       <= deg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        pk_reg  <= pk_next;
        pk1_reg <= pk1_next;
        pk2_reg <= pk2_next;
        t_reg   <= t_next;
        v_reg   <= v_next;
        vp_reg  <= vp_next;
        vpp_reg <= vpp_next;
        sat_reg <= sat_next;
        if (out_load)
        begin
            poly_reg    <= v_reg;
            first_reg   <= vp_reg;
            second_reg  <= vpp_reg;
            sat_out_reg <= sat_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign poly_value   = poly_reg;
    assign first_deriv  = first_reg;
    assign second_deriv = second_reg;
    assign saturated    = sat_out_reg;

endmodule

[bench/polynomial_eval_with_derivatives_tb.sv]
// testbench for polynomial_eval_with_derivatives: directed table, then random load and
// evaluate traffic over several degree settings, checked against table values or an in-bench fixed-point model
// depends on pev_pkg and the polynomial_eval_with_derivatives rtl
module polynomial_eval_with_derivatives_tb;
    import pev_pkg::*;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;
    localparam int STORE_DEPTH = 256;

    typedef struct packed {
        logic signed [63:0] poly;
        logic signed [63:0] d1;
        logic signed [63:0] d2;
        logic               sat;
    } eval_result_t;

    typedef struct {
        logic [7:0]   deg;
        logic         op;
        logic [7:0]   idx;
        logic [31:0]  cval;
        logic [31:0]  x;
        bit           typed;
        eval_result_t res;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         degree = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = OP_LOAD;
    logic [7:0]         coef_index = '0;
    logic signed [31:0] coef_value = '0;
    logic signed [31:0] x_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] poly_value;
    logic signed [63:0] first_deriv;
    logic signed [63:0] second_deriv;
    logic               saturated;

    logic signed [31:0] coef_store [STORE_DEPTH];
    bit                 coef_written [STORE_DEPTH];
    logic [7:0]         cur_degree = '0;
    bit                 sat_seen;
    eval_result_t       pending_results [$];
    eval_result_t       got;
    int                 mismatches = 0;
    int                 snd_idle_pct = 0;
    int                 rcv_idle_pct = 0;
    int                 hold_left = 0;
    bit                 hold_req = 1'b0;

    polynomial_eval_with_derivatives dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .degree       (degree),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .x_value      (x_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .poly_value   (poly_value),
        .first_deriv  (first_deriv),
        .second_deriv (second_deriv),
        .saturated    (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // (a * b) >> s, truncated toward zero, saturated to 64 bits
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b,
                                                          input int unsigned s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] m;
        neg = a[63] != b[63];
        ua = a[63] ? (~a + 64'd1) : a;
        ub = b[63] ? (~b + 64'd1) : b;
        m = ({64'd0, ua} * {64'd0, ub}) >> s;
        if (m > (neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF))
        begin
            sat_seen = 1'b1;
            return neg ? SAT_MIN : SAT_MAX;
        end
        return neg ? -m[63:0] : m[63:0];
    endfunction

    function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat_seen = 1'b1;
            return a[63] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

    function automatic eval_result_t poly_with_derivs(input logic signed [31:0] xq);
        logic signed [63:0] xv;
        logic signed [63:0] a;
        logic signed [63:0] pk;
        logic signed [63:0] pk1;
        logic signed [63:0] pk2;
        eval_result_t       r;
        xv = xq;
        pk = Q32_ONE;
        pk1 = '0;
        pk2 = '0;
        r = '0;
        sat_seen = 1'b0;
        for (int k = 0; k <= int'(cur_degree); k++)
        begin
            a = coef_store[k];
            if (k > 0)
            begin
                pk2 = pk1;
                pk1 = pk;
                pk = scaled_product(pk, xv, 16);
            end
            r.poly = sum_sat(r.poly, scaled_product(pk, a, 16));
            if (k >= 1)
                r.d1 = sum_sat(r.d1, scaled_product(scaled_product(pk1, a, 16), 64'(k), 0));
            if (k >= 2)
                r.d2 = sum_sat(r.d2, scaled_product(scaled_product(pk2, a, 16),
                                                    64'(k * (k - 1)), 0));
        end
        r.sat = sat_seen;
        return r;
    endfunction

    // mix of extremes and zero, values of magnitude at most two, mid-range and full-range q16.16 numbers
    function automatic logic [31:0] pick_q16();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4, 5: return {{14{r[17]}}, r[17:0]};
            6, 7: return {{8{r[23]}}, r[23:0]};
            default: return r;
        endcase
    endfunction

    task automatic send_item(input logic o, input logic [7:0] i, input logic [31:0] c,
                             input logic [31:0] xv, input bit typed,
                             input eval_result_t typed_res);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        coef_index <= i;
        coef_value <= c;
        x_value <= xv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (o == OP_LOAD)
        begin
            coef_store[i] = c;
            coef_written[i] = 1'b1;
        end
        else
            pending_results.push_back(typed ? typed_res : poly_with_derivs(xv));
        @(negedge clk);
    endtask

    task automatic set_degree(input logic [7:0] d);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        degree <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_degree = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] have);
        if (want !== have)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, have);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            out_stall <= 1'b1;
            hold_left = 2000;
            hold_req = 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transaction with nothing expected: %h %h %h %b",
                             poly_value, first_deriv, second_deriv, saturated);
            end
            else
            begin
                got = pending_results.pop_front();
                check_field("poly_value", got.poly, poly_value);
                check_field("first_deriv", got.d1, first_deriv);
                check_field("second_deriv", got.d2, second_deriv);
                check_field("saturated", 64'(got.sat), 64'(saturated));
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        static dir_row_t rows [] = '{
            '{8'd0, OP_LOAD, 8'd0, 32'h0001_0000, 32'h0, 1'b0, '0},
            '{8'd0, OP_EVAL, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
              '{64'h0000_0001_0000_0000, 64'h0, 64'h0, 1'b0}},
            '{8'd0, OP_LOAD, 8'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{8'd0, OP_EVAL, 8'd0, 32'h0, 32'h8000_0000, 1'b1,
              '{64'h0000_7FFF_FFFF_0000, 64'h0, 64'h0, 1'b0}},
            '{8'd0, OP_LOAD, 8'd0, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{8'd0, OP_EVAL, 8'd0, 32'h0, 32'h7FFF_FFFF, 1'b1,
              '{64'hFFFF_8000_0000_0000, 64'h0, 64'h0, 1'b0}},
            '{8'd1, OP_LOAD, 8'd1, 32'h0002_0000, 32'h0, 1'b0, '0},
            '{8'd1, OP_EVAL, 8'd0, 32'h0, 32'h0001_0000, 1'b0, '0},
            '{8'd1, OP_EVAL, 8'd0, 32'h0, 32'hFFFF_0000, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd2, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd1, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
            '{8'd2, OP_EVAL, 8'd0, 32'h0, 32'h7FFF_FFFF, 1'b0, '0},
            '{8'd2, OP_EVAL, 8'd0, 32'h0, 32'h8000_0000, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd255, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{8'd2, OP_EVAL, 8'd0, 32'h0, 32'h0001_8000, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd0, 32'h0, 32'h0, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd1, 32'h0, 32'h0, 1'b0, '0},
            '{8'd2, OP_LOAD, 8'd2, 32'h0, 32'h0, 1'b0, '0},
            '{8'd2, OP_EVAL, 8'd0, 32'h0, 32'h1234_5678, 1'b1, '{64'h0, 64'h0, 64'h0, 1'b0}},
            '{8'd3, OP_LOAD, 8'd3, 32'hFFFF_0000, 32'h0, 1'b0, '0},
            '{8'd3, OP_EVAL, 8'd0, 32'h0, 32'h0002_0000, 1'b0, '0},
            '{8'd3, OP_EVAL, 8'd0, 32'h0, 32'h8000_0000, 1'b0, '0}
        };
        logic [7:0] d;
        int         n_items;
        int         guard;

        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            coef_store[k] = '0;
            coef_written[k] = 1'b0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[r])
        begin
            if (rows[r].deg != cur_degree)
                set_degree(rows[r].deg);
            send_item(rows[r].op, rows[r].idx, rows[r].cval, rows[r].x, rows[r].typed,
                      rows[r].res);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            snd_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 53 : 0;
            rcv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 24 : 0;
            for (int ph = 0; ph < 4; ph++)
            begin
                if (ph == 3 && mode != 1)
                    d = 8'd255;
                else
                    d = 8'($urandom_range(0, (ph == 2) ? 12 : 5));
                n_items = (d == 8'd255) ? 8 : 220;
                set_degree(d);
                // every coefficient an evaluation reads must have been loaded
                for (int k = 0; k <= int'(d); k++)
                    if (!coef_written[k])
                        send_item(OP_LOAD, 8'(k), pick_q16(), $urandom, 1'b0, '0);
                if (mode == 2 && ph == 0)
                    hold_req = 1'b1;
                for (int n = 0; n < n_items; n++)
                begin
                    if ($urandom_range(99) < 35)
                        send_item(OP_LOAD, 8'($urandom_range(0, 255)), pick_q16(), $urandom,
                                  1'b0, '0);
                    else
                        send_item(OP_EVAL, 8'($urandom), $urandom, pick_q16(), 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
design/pev_pkg.sv
design/pev_ram.sv
design/pev_mul.sv
design/polynomial_eval_with_derivatives.sv
bench/polynomial_eval_with_derivatives_tb.sv
